@@ hdl/srpcm_pkg.sv @@
// shared constants, word types and inter-module structs for the stereo rms/peak/clip meter
// used by srpcm_lane, srpcm_rms and stereo_rms_peak_clip_meter_core; no dependencies
package srpcm_pkg;

	// sample format and field widths
	localparam int SAMPLE_BITS = 24;
	localparam int MAX_BLOCK   = 4096;
	localparam int BLEN_W      = 13;
	localparam int DUR_W       = 19;
	localparam int CHAN_W      = 2;
	localparam int TOT_W       = 32;
	localparam int RMS_W       = SAMPLE_BITS - 1;

	// datapath widths
	localparam int MAG_W  = SAMPLE_BITS;
	localparam int SQ_W   = 2 * SAMPLE_BITS - 1;
	localparam int SUM_W  = SQ_W + BLEN_W;
	localparam int CLIP_W = BLEN_W;
	localparam int DIV_W  = SUM_W + 1;
	localparam int DVR_W  = BLEN_W + 1;
	localparam int ROOT_W = SAMPLE_BITS;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = DUR_W;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCK = 2'd2;

	// register reset values and codes
	localparam logic [CHAN_W-1:0] CHAN_RESET    = 2'd1;
	localparam logic [CHAN_W-1:0] CHAN_STEREO   = 2'd2;
	localparam logic [DUR_W-1:0]  DUR_RESET     = 19'd480000;
	localparam logic [BLEN_W-1:0] MAXBLK_RESET  = 13'd4096;
	localparam logic [MAG_W-1:0]  MAG_ONE       = MAG_W'(1) << (SAMPLE_BITS - 2);

	// input word
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
		logic                          left_invalid;
		logic                          right_invalid;
		logic [BLEN_W-1:0]             block_length;
		logic                          last_of_block;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [RMS_W-1:0] left_rms;
		logic [RMS_W-1:0] right_rms;
		logic [RMS_W-1:0] combined_rms;
		logic [MAG_W-1:0] peak_level;
		logic [TOT_W-1:0] clip_total;
		logic [TOT_W-1:0] block_total;
		logic [TOT_W-1:0] frame_total;
		logic             error_code;
		logic             still_active;
	} out_word_t;

	// per-channel lane status toward the merge logic
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [MAG_W-1:0]  peak;
		logic [CLIP_W-1:0] clips;
		logic              busy;
	} lane_stat_t;

	// request and response of the shared divide / square root unit
	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVR_W-1:0] divisor;
	} rms_req_t;

	typedef struct packed {
		logic             done;
		logic [RMS_W-1:0] value;
	} rms_rsp_t;

endpackage

@@ hdl/stereo_rms_peak_clip_meter_core.sv @@
// stereo rms/peak/clip meter: one frame word per cycle while in_ready is high
// non-final frames keep in_ready; a block's final frame: lane drain and merge, then 3 jobs in
// the shared rms unit (start, 61 divide steps, 24 root steps, done), then the hold state until
// the output register is free, all without in_ready; an over-long block goes straight to hold
// reset (arst_n low) sets the registers to their defaults, metering running, totals zero
// depends on srpcm_pkg, srpcm_lane, srpcm_rms
module stereo_rms_peak_clip_meter_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  srpcm_pkg::in_word_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output srpcm_pkg::out_word_t                 out_data,
	input  logic                                 cfg_we,
	input  logic [srpcm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [srpcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_FLUSH = 5'b00010,
		ST_START = 5'b00100,
		ST_WAIT  = 5'b01000,
		ST_HOLD  = 5'b10000
	} state_t;

	typedef enum logic [1:0] {
		JOB_LEFT  = 2'd0,
		JOB_RIGHT = 2'd1,
		JOB_COMB  = 2'd2
	} job_t;

	function automatic logic [srpcm_pkg::TOT_W-1:0] sat_add(
		input logic [srpcm_pkg::TOT_W-1:0] a,
		input logic [srpcm_pkg::TOT_W-1:0] b
	);
		logic [srpcm_pkg::TOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[srpcm_pkg::TOT_W] ? '1 : s[srpcm_pkg::TOT_W-1:0];
	endfunction

	// configuration
	logic [srpcm_pkg::CHAN_W-1:0]  chan_q;
	logic [srpcm_pkg::DUR_W-1:0]   dur_q;
	logic [srpcm_pkg::BLEN_W-1:0]  maxblk_q;

	// meter state
	state_t                        state_q;
	job_t                          job_q;
	logic                          running_q;
	logic                          in_block_q;
	logic                          error_q;
	logic [srpcm_pkg::DUR_W-1:0]   frame_pos_q;
	logic [srpcm_pkg::BLEN_W-1:0]  blk_cnt_q;
	logic [srpcm_pkg::MAG_W-1:0]   run_peak_q;
	logic [srpcm_pkg::TOT_W-1:0]   clip_tot_q;
	logic [srpcm_pkg::TOT_W-1:0]   blk_tot_q;
	logic [srpcm_pkg::TOT_W-1:0]   frm_tot_q;
	logic [srpcm_pkg::RMS_W-1:0]   lrms_q;
	logic [srpcm_pkg::RMS_W-1:0]   rrms_q;
	logic [srpcm_pkg::RMS_W-1:0]   crms_q;
	logic                          out_valid_q;
	srpcm_pkg::out_word_t          out_q;

	// frame decode
	logic                          stereo;
	logic                          acc;
	logic [srpcm_pkg::BLEN_W:0]    lim;
	logic                          err_start;
	logic                          dur_stop;
	logic                          open;
	logic [srpcm_pkg::BLEN_W-1:0]  cnt_eff;
	logic                          proc;
	logic                          lane_clear;
	logic                          lane_busy;

	// merge
	srpcm_pkg::lane_stat_t         lstat;
	srpcm_pkg::lane_stat_t         rstat;
	logic [srpcm_pkg::MAG_W-1:0]   blk_peak;
	logic [srpcm_pkg::CLIP_W:0]    blk_clips;

	srpcm_pkg::rms_req_t           req;
	srpcm_pkg::rms_rsp_t           rsp;
	srpcm_pkg::out_word_t          res;

	assign stereo   = (chan_q == srpcm_pkg::CHAN_STEREO);
	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid & in_ready;

	// block start checks against the effective length limit
	assign lim = ({1'b0, maxblk_q} < (srpcm_pkg::BLEN_W + 1)'(srpcm_pkg::MAX_BLOCK)) ?
		{1'b0, maxblk_q} : (srpcm_pkg::BLEN_W + 1)'(srpcm_pkg::MAX_BLOCK);
	assign err_start  = running_q & ~in_block_q & ({1'b0, in_data.block_length} > lim);
	assign dur_stop   = running_q & ~in_block_q & ~err_start & (frame_pos_q >= dur_q);
	assign open       = running_q & ~err_start & ~dur_stop;
	assign cnt_eff    = in_block_q ? blk_cnt_q : '0;
	assign proc       = open & (frame_pos_q < dur_q) & (cnt_eff < in_data.block_length);
	assign lane_clear = acc & open & ~in_block_q;

	// channel lanes
	srpcm_lane u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.enable  (1'b1),
		.clear   (lane_clear),
		.load    (acc & proc),
		.sample  (in_data.left_sample),
		.invalid (in_data.left_invalid),
		.stat    (lstat)
	);

	srpcm_lane u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.enable  (stereo),
		.clear   (lane_clear),
		.load    (acc & proc),
		.sample  (in_data.right_sample),
		.invalid (in_data.right_invalid),
		.stat    (rstat)
	);

	assign lane_busy = lstat.busy | rstat.busy;
	assign blk_peak  = (lstat.peak > rstat.peak) ? lstat.peak : rstat.peak;
	assign blk_clips = {1'b0, lstat.clips} + {1'b0, rstat.clips};

	// operand select for the shared rms unit
	always_comb begin
		req.start    = (state_q == ST_START);
		req.dividend = srpcm_pkg::DIV_W'(lstat.sum);
		req.divisor  = srpcm_pkg::DVR_W'(blk_cnt_q);
		case (job_q)
			JOB_LEFT: begin
				req.dividend = srpcm_pkg::DIV_W'(lstat.sum);
			end
			JOB_RIGHT: begin
				req.dividend = srpcm_pkg::DIV_W'(rstat.sum);
			end
			JOB_COMB: begin
				if (stereo) begin
					req.dividend = srpcm_pkg::DIV_W'(lstat.sum) + srpcm_pkg::DIV_W'(rstat.sum);
					req.divisor  = {blk_cnt_q, 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	srpcm_rms u_rms (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= srpcm_pkg::CHAN_RESET;
			dur_q    <= srpcm_pkg::DUR_RESET;
			maxblk_q <= srpcm_pkg::MAXBLK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				srpcm_pkg::CFG_CHANNELS:  chan_q   <= cfg_data[srpcm_pkg::CHAN_W-1:0];
				srpcm_pkg::CFG_DURATION:  dur_q    <= cfg_data[srpcm_pkg::DUR_W-1:0];
				srpcm_pkg::CFG_MAX_BLOCK: maxblk_q <= cfg_data[srpcm_pkg::BLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// frame intake, block end merge and job sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_LEFT;
			running_q   <= 1'b1;
			in_block_q  <= 1'b0;
			error_q     <= 1'b0;
			frame_pos_q <= '0;
			blk_cnt_q   <= '0;
			run_peak_q  <= '0;
			clip_tot_q  <= '0;
			blk_tot_q   <= '0;
			frm_tot_q   <= '0;
			lrms_q      <= '0;
			rrms_q      <= '0;
			crms_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (err_start) begin
							error_q   <= 1'b1;
							running_q <= 1'b0;
							lrms_q    <= '0;
							rrms_q    <= '0;
							crms_q    <= '0;
							state_q   <= ST_HOLD;
						end else if (dur_stop) begin
							running_q <= 1'b0;
						end else if (open) begin
							blk_cnt_q <= proc ? cnt_eff + 1'b1 : cnt_eff;
							if (proc) begin
								frame_pos_q <= frame_pos_q + 1'b1;
							end
							if (in_data.last_of_block) begin
								in_block_q <= 1'b0;
								state_q    <= ST_FLUSH;
							end else begin
								in_block_q <= 1'b1;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (!lane_busy) begin
						if (blk_peak > run_peak_q) begin
							run_peak_q <= blk_peak;
						end
						clip_tot_q <= sat_add(clip_tot_q, srpcm_pkg::TOT_W'(blk_clips));
						frm_tot_q  <= sat_add(frm_tot_q, srpcm_pkg::TOT_W'(blk_cnt_q));
						blk_tot_q  <= sat_add(blk_tot_q, srpcm_pkg::TOT_W'(1));
						if (frame_pos_q >= dur_q) begin
							running_q <= 1'b0;
						end
						job_q   <= JOB_LEFT;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (rsp.done) begin
						case (job_q)
							JOB_LEFT: begin
								lrms_q  <= rsp.value;
								job_q   <= JOB_RIGHT;
								state_q <= ST_START;
							end
							JOB_RIGHT: begin
								rrms_q  <= rsp.value;
								job_q   <= JOB_COMB;
								state_q <= ST_START;
							end
							default: begin
								crms_q  <= rsp.value;
								state_q <= ST_HOLD;
							end
						endcase
					end
				end
				ST_HOLD: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word assembled from the block results and totals
	always_comb begin
		res.left_rms     = lrms_q;
		res.right_rms    = rrms_q;
		res.combined_rms = crms_q;
		res.peak_level   = run_peak_q;
		res.clip_total   = clip_tot_q;
		res.block_total  = blk_tot_q;
		res.frame_total  = frm_tot_q;
		res.error_code   = error_q;
		res.still_active = running_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && (!out_valid_q || out_ready)) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// an error stops metering for good
	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		error_q |-> !running_q)
		else $error("error latched while still running");

	// the rms unit only reports back while a job is outstanding
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == ST_WAIT)
		else $error("rms result outside of wait state");

	// a new result word only comes from the hold state
	a_out_from_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_HOLD))
		else $error("result word loaded outside of hold state");

	// lane pipelines must be empty before the block sums are used
	a_lane_drain: assert property (@(posedge clk) disable iff (!arst_n)
		lane_busy |-> (state_q == ST_IDLE || state_q == ST_FLUSH))
		else $error("lane pipeline busy during block end processing");

endmodule

@@ hdl/srpcm_lane.sv @@
// one metering lane: magnitude, clip detect, square and per-block accumulators
// depends on srpcm_pkg
module srpcm_lane (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 enable,
	input  logic                                 clear,
	input  logic                                 load,
	input  logic signed [srpcm_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                 invalid,
	output srpcm_pkg::lane_stat_t                stat
);

	logic [srpcm_pkg::MAG_W-1:0]    raw;
	logic [srpcm_pkg::MAG_W-1:0]    mag;
	logic                           clip;
	logic [2*srpcm_pkg::MAG_W-1:0]  prod;

	logic                           vld_s1;
	logic [srpcm_pkg::MAG_W-1:0]    mag_s1;
	logic                           clip_s1;
	logic                           vld_s2;
	logic [srpcm_pkg::SQ_W-1:0]     sq_s2;

	logic [srpcm_pkg::SUM_W-1:0]    sum_q;
	logic [srpcm_pkg::MAG_W-1:0]    peak_q;
	logic [srpcm_pkg::CLIP_W-1:0]   clips_q;

	// magnitude of the sample, zero when invalid or channel unused
	assign raw = sample;
	always_comb begin
		if (!enable || invalid) begin
			mag = '0;
		end else if (raw[srpcm_pkg::MAG_W-1]) begin
			mag = ~raw + 1'b1;
		end else begin
			mag = raw;
		end
	end

	assign clip = enable & (invalid | (mag >= srpcm_pkg::MAG_ONE));
	assign prod = mag_s1 * mag_s1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= load;
			vld_s2 <= vld_s1;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		clip_s1 <= clip;
		sq_s2   <= prod[srpcm_pkg::SQ_W-1:0];
	end

	// block accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			peak_q  <= '0;
			clips_q <= '0;
		end else if (clear) begin
			sum_q   <= '0;
			peak_q  <= '0;
			clips_q <= '0;
		end else begin
			if (vld_s1) begin
				if (mag_s1 > peak_q) begin
					peak_q <= mag_s1;
				end
				if (clip_s1) begin
					clips_q <= clips_q + 1'b1;
				end
			end
			if (vld_s2) begin
				sum_q <= sum_q + srpcm_pkg::SUM_W'(sq_s2);
			end
		end
	end

	assign stat.sum   = sum_q;
	assign stat.peak  = peak_q;
	assign stat.clips = clips_q;
	assign stat.busy  = vld_s1 | vld_s2;

endmodule

@@ hdl/srpcm_rms.sv @@
// shared rms unit: bit-serial restoring divide then digit-by-digit square root
// depends on srpcm_pkg
module srpcm_rms (
	input  logic                clk,
	input  logic                arst_n,
	input  srpcm_pkg::rms_req_t req,
	output srpcm_pkg::rms_rsp_t rsp
);

	localparam int STEP_W = $clog2(srpcm_pkg::DIV_W);
	localparam int RAD_W  = 2 * srpcm_pkg::ROOT_W;

	typedef enum logic [3:0] {
		RS_IDLE = 4'b0001,
		RS_DIV  = 4'b0010,
		RS_ROOT = 4'b0100,
		RS_DONE = 4'b1000
	} rstate_t;

	rstate_t                        state_q;
	logic [STEP_W-1:0]              step_q;
	logic [srpcm_pkg::DVR_W-1:0]    dvr_q;
	logic [srpcm_pkg::DIV_W-1:0]    quo_q;
	logic [srpcm_pkg::DVR_W-1:0]    rem_q;
	logic                           zero_q;
	logic [RAD_W-1:0]               rad_q;
	logic [srpcm_pkg::ROOT_W:0]     srem_q;
	logic [srpcm_pkg::ROOT_W-1:0]   root_q;

	logic [srpcm_pkg::DVR_W:0]      dtry;
	logic [srpcm_pkg::DVR_W:0]      ddiff;
	logic                           dge;
	logic [srpcm_pkg::ROOT_W+2:0]   stry;
	logic [srpcm_pkg::ROOT_W+2:0]   strial;
	logic [srpcm_pkg::ROOT_W+2:0]   sdiff;
	logic                           sge;

	// one quotient bit per cycle
	assign dtry  = {rem_q, quo_q[srpcm_pkg::DIV_W-1]};
	assign dge   = dtry >= {1'b0, dvr_q};
	assign ddiff = dtry - {1'b0, dvr_q};

	// one root bit per cycle
	assign stry   = {srem_q, rad_q[RAD_W-1 -: 2]};
	assign strial = {1'b0, root_q, 2'b01};
	assign sge    = stry >= strial;
	assign sdiff  = stry - strial;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RS_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				RS_IDLE: begin
					if (req.start) begin
						state_q <= RS_DIV;
						step_q  <= STEP_W'(srpcm_pkg::DIV_W - 1);
					end
				end
				RS_DIV: begin
					if (step_q == '0) begin
						state_q <= RS_ROOT;
						step_q  <= STEP_W'(srpcm_pkg::ROOT_W - 1);
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				RS_ROOT: begin
					if (step_q == '0) begin
						state_q <= RS_DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				RS_DONE: begin
					state_q <= RS_IDLE;
				end
				default: begin
					state_q <= RS_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			RS_IDLE: begin
				if (req.start) begin
					dvr_q  <= req.divisor;
					quo_q  <= req.dividend;
					rem_q  <= '0;
					zero_q <= (req.divisor == '0);
				end
			end
			RS_DIV: begin
				rem_q <= dge ? ddiff[srpcm_pkg::DVR_W-1:0] : dtry[srpcm_pkg::DVR_W-1:0];
				quo_q <= {quo_q[srpcm_pkg::DIV_W-2:0], dge};
				if (step_q == '0) begin
					rad_q  <= {quo_q[RAD_W-2:0], dge};
					srem_q <= '0;
					root_q <= '0;
				end
			end
			RS_ROOT: begin
				srem_q <= sge ? sdiff[srpcm_pkg::ROOT_W:0] : stry[srpcm_pkg::ROOT_W:0];
				root_q <= {root_q[srpcm_pkg::ROOT_W-2:0], sge};
				rad_q  <= rad_q << 2;
			end
			default: begin
			end
		endcase
	end

	// saturated result, zero for an empty block
	assign rsp.done  = (state_q == RS_DONE);
	assign rsp.value = zero_q ? '0 :
		(root_q[srpcm_pkg::ROOT_W-1] ? '1 : root_q[srpcm_pkg::RMS_W-1:0]);

endmodule
